>>> rtl/pst_pkg.sv
`default_nettype none
package pst_pkg;
    localparam int unsigned SieveLimitDef = 65536;
    localparam int unsigned PrimeSlotsDef = 8192;
    localparam int unsigned NumW          = 32;
    localparam int unsigned PosW          = 16;
    localparam int unsigned ValW          = 17;
    localparam int unsigned CntW          = 14;

    localparam logic FUNC_TEST   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic            func;
        logic [NumW-1:0] number;
        logic [PosW-1:0] position;
    } t_req;

    typedef struct packed {
        logic            is_prime;
        logic            found;
        logic [ValW-1:0] prime_value;
        logic [CntW-1:0] prime_count;
    } t_rsp;
endpackage
`default_nettype wire

>>> rtl/prime_sieve_and_test.sv
// channel  | signals                  | beat
// ---------+--------------------------+-------------------------------------
// request  | i_start, o_busy, i_req   | i_start high while o_busy low
// result   | o_valid, o_rsp           | o_valid high for one cycle
//
// cycles: after reset a clearing pass sweeps the smallest-factor store, one
// entry a cycle, with o_busy high.
// the first request then runs the linear sieve before it is served.
// a test runs one bit-serial remainder per stored prime until p*p exceeds the
// number, a stored prime divides it or the table runs out.
// reset is synchronous, active low; the receiver cannot stall results.
`default_nettype none
module prime_sieve_and_test #(
    parameter int unsigned SIEVE_LIMIT = pst_pkg::SieveLimitDef,
    parameter int unsigned PRIME_SLOTS = pst_pkg::PrimeSlotsDef
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pst_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_valid,
    output pst_pkg::t_rsp      o_rsp
);
    import pst_pkg::*;

    localparam int unsigned AW  = $clog2(SIEVE_LIMIT + 1);
    localparam int unsigned PW  = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
    localparam int unsigned IW  = $clog2(PRIME_SLOTS + 1);
    localparam int unsigned VW  = AW;
    localparam int unsigned MW  = 2 * VW + 1;
    localparam int unsigned BCW = $clog2(NumW + 1);
    localparam int unsigned CW  = (IW > PosW) ? IW : PosW + 1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SV_RD, S_SV_WT, S_SV_CHK, S_SV_JRD, S_SV_JWT,
        S_SV_JCHK, S_LK_RD, S_LK_WT, S_LK_OUT, S_TS_RD, S_TS_WT, S_TS_SQ,
        S_TS_DIV, S_TS_CHK, S_DONE
    } t_state;

    // stores
    logic [IW-1:0]   r_fmem [0:SIEVE_LIMIT];
    logic [VW-1:0]   r_pmem [0:PRIME_SLOTS-1];
    logic [IW-1:0]   r_fq;
    logic [VW-1:0]   r_pq;

    t_state          r_state;
    logic [AW-1:0]   r_i;
    logic [IW-1:0]   r_j;
    logic [IW-1:0]   r_fi;
    logic [IW-1:0]   r_cnt;
    logic            r_built;
    logic            r_func;
    logic [NumW-1:0] r_num;
    logic [PosW-1:0] r_pos;
    logic [VW-1:0]   r_p;
    logic [MW-1:0]   r_m;
    logic [NumW-1:0] r_sh;
    logic [VW:0]     r_rem;
    logic [BCW-1:0]  r_bc;
    logic            r_isp;
    logic            r_fnd;
    logic [VW-1:0]   r_val;

    // store write/read controls
    logic            fwe;
    logic [AW-1:0]   fwa;
    logic [IW-1:0]   fwd;
    logic [AW-1:0]   fra;
    logic            pwe;
    logic [PW-1:0]   pa;
    logic [VW:0]     rem_sh;
    logic [VW:0]     rem_sub;

    // smallest-factor store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (fwe) begin
            r_fmem[fwa] <= fwd;
        end
        r_fq <= r_fmem[fra];
    end

    // prime table
    always_ff @(posedge i_clk) begin
        if (pwe) begin
            r_pmem[pa] <= r_i[VW-1:0];
        end
        r_pq <= r_pmem[pa];
    end

    // store port selection
    always_comb begin
        fwe = 1'b0;
        fwa = r_i;
        fwd = '0;
        fra = r_i;
        pwe = 1'b0;
        pa  = r_j[PW-1:0];
        case (r_state)
            S_CLEAR: begin
                fwe = 1'b1;
            end
            S_SV_CHK: begin
                if (r_fq == '0 && r_cnt < IW'(PRIME_SLOTS)) begin
                    fwe = 1'b1;
                    fwd = r_cnt + 1'b1;
                    pwe = 1'b1;
                    pa  = r_cnt[PW-1:0];
                end
            end
            S_SV_JCHK: begin
                if (r_m <= MW'(SIEVE_LIMIT)) begin
                    fwe = 1'b1;
                    fwa = r_m[AW-1:0];
                    fwd = r_j + 1'b1;
                end
            end
            // hold the lookup address until the table word is used
            S_LK_RD, S_LK_WT: begin
                pa = PW'(r_pos);
            end
            default: begin
            end
        endcase
    end

    // one restoring remainder step per cycle
    assign rem_sh  = {r_rem[VW-1:0], r_sh[NumW-1]};
    assign rem_sub = rem_sh - {1'b0, r_p};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_i     <= '0;
            r_cnt   <= '0;
            r_built <= 1'b0;
            o_valid <= 1'b0;
            o_busy  <= 1'b1;
        end else begin
            o_valid <= (r_state == S_DONE);
            case (r_state)
                S_CLEAR: begin
                    if (r_i == AW'(SIEVE_LIMIT)) begin
                        r_state <= S_IDLE;
                        o_busy  <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        o_busy <= 1'b1;
                        r_func <= i_req.func;
                        r_num  <= i_req.number;
                        r_pos  <= i_req.position;
                        r_isp  <= 1'b0;
                        r_fnd  <= 1'b0;
                        r_val  <= '0;
                        if (!r_built) begin
                            r_i     <= AW'(2);
                            r_state <= S_SV_RD;
                        end else if (i_req.func == FUNC_LOOKUP) begin
                            r_state <= S_LK_RD;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_TS_RD;
                        end
                    end
                end
                // sieve: read entry i
                S_SV_RD: r_state <= S_SV_WT;
                S_SV_WT: r_state <= S_SV_CHK;
                S_SV_CHK: begin
                    if (r_fq == '0) begin
                        if (r_cnt >= IW'(PRIME_SLOTS)) begin
                            r_built <= 1'b1;
                            r_state <= (r_func == FUNC_LOOKUP) ? S_LK_RD : S_TS_RD;
                            r_j     <= '0;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_fi    <= r_cnt + 1'b1;
                            r_j     <= '0;
                            r_state <= S_SV_JRD;
                        end
                    end else begin
                        r_fi    <= r_fq;
                        r_j     <= '0;
                        r_state <= S_SV_JRD;
                    end
                end
                S_SV_JRD: begin
                    if (r_j < r_fi && r_j < r_cnt) begin
                        r_state <= S_SV_JWT;
                    end else if (r_i == AW'(SIEVE_LIMIT)) begin
                        r_built <= 1'b1;
                        r_j     <= '0;
                        r_state <= (r_func == FUNC_LOOKUP) ? S_LK_RD : S_TS_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SV_RD;
                    end
                end
                S_SV_JWT: begin
                    r_m     <= MW'(r_i) * MW'(r_pq);
                    r_state <= S_SV_JCHK;
                end
                S_SV_JCHK: begin
                    if (r_m > MW'(SIEVE_LIMIT)) begin
                        r_fi <= r_j;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    r_state <= S_SV_JRD;
                end
                // lookup
                S_LK_RD: r_state <= S_LK_WT;
                S_LK_WT: r_state <= S_LK_OUT;
                S_LK_OUT: begin
                    if (CW'(r_pos) < CW'(r_cnt)) begin
                        r_fnd <= 1'b1;
                        r_val <= r_pq;
                    end
                    r_state <= S_DONE;
                end
                // test: fetch prime j
                S_TS_RD: begin
                    if (r_num < NumW'(2)) begin
                        r_state <= S_DONE;
                    end else if (r_j >= r_cnt) begin
                        r_isp   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TS_WT;
                    end
                end
                S_TS_WT: begin
                    r_p     <= r_pq;
                    r_state <= S_TS_SQ;
                end
                S_TS_SQ: begin
                    r_m     <= MW'(r_p) * MW'(r_p);
                    r_sh    <= r_num;
                    r_rem   <= '0;
                    r_bc    <= '0;
                    r_state <= S_TS_DIV;
                end
                S_TS_DIV: begin
                    r_sh <= r_sh << 1;
                    r_rem <= rem_sub[VW] ? rem_sh : rem_sub;
                    if (r_bc == BCW'(NumW - 1)) begin
                        r_state <= S_TS_CHK;
                    end
                    r_bc <= r_bc + 1'b1;
                end
                S_TS_CHK: begin
                    if (r_m > MW'(r_num)) begin
                        r_isp   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_p != '0 && r_rem == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_TS_RD;
                    end
                end
                S_DONE: begin
                    o_rsp.is_prime      <= r_isp;
                    o_rsp.found         <= r_fnd;
                    o_rsp.prime_value   <= ValW'(r_val);
                    o_rsp.prime_count   <= CntW'(r_cnt);
                    o_busy              <= 1'b0;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/pst_check.sv
`default_nettype none
module pst_check (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          o_busy,
    input wire logic          o_valid,
    input wire pst_pkg::t_rsp o_rsp
);
    // a result only closes a busy request
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result without request");
    // one-cycle strobe
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe too long");
    // accepted beat makes block busy
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("beat not taken");
    // a result that claims prime never claims found
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.is_prime) |-> !o_rsp.found) else $error("mixed result");
endmodule

bind prime_sieve_and_test pst_check u_pst_check (.*);
`default_nettype wire

>>> tb/prime_sieve_and_test_test.sv
`default_nettype none
module prime_sieve_and_test_test;
    import pst_pkg::*;

    // prime table and expected answers, kept apart from the block
    class prime_scoreboard;
        int unsigned primes[$];
        t_rsp        answers_due[$];
        int unsigned n_tests, n_lookups, n_checked, n_mismatch;

        function new();
            bit composite [0:SieveLimitDef];
            int unsigned i, j;
            for (i = 0; i <= SieveLimitDef; i++) composite[i] = 1'b0;
            for (i = 2; i <= SieveLimitDef; i++) begin
                if (!composite[i]) begin
                    if (primes.size() < PrimeSlotsDef) primes.insert(primes.size(), i);
                    for (j = i * 2; j <= SieveLimitDef; j += i) composite[j] = 1'b1;
                end
            end
        endfunction

        // trial division by stored primes until p*p passes the number
        function bit prime_by_division(logic [NumW-1:0] n);
            longint unsigned p;
            if (n < 2) return 1'b0;
            foreach (primes[k]) begin
                p = primes[k];
                if (p * p > longint'(n)) return 1'b1;
                if (longint'(n) % p == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(t_req req);
            t_rsp r;
            r = '0;
            r.prime_count = CntW'(primes.size());
            if (req.func == FUNC_TEST) begin
                r.is_prime = prime_by_division(req.number);
                n_tests++;
            end else begin
                n_lookups++;
                if (req.position < primes.size()) begin
                    r.found       = 1'b1;
                    r.prime_value = ValW'(primes[req.position]);
                end
            end
            answers_due.insert(answers_due.size(), r);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            n_checked++;
            if (answers_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("result beat with nothing pending: %p", got);
                return;
            end
            want = answers_due.pop_front();
            if (got !== want) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start;
    t_req i_req;
    logic o_busy, o_valid;
    t_rsp o_rsp;

    prime_sieve_and_test DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    prime_scoreboard sb = new();
    int unsigned gap_max;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_result(o_rsp);
    end

    // hold a request until the block takes it, then idle for a random gap, if any
    task automatic send_request(logic f, logic [NumW-1:0] n, logic [PosW-1:0] pos);
        t_req r;
        int unsigned gap;
        r.func = f; r.number = n; r.position = pos;
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        sb.note_request(r);
        gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sel;
        logic [NumW-1:0] n;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req   <= '0;
        gap_max = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of both operations
        send_request(FUNC_TEST, 0, 0);
        send_request(FUNC_TEST, 1, 16'hFFFF);
        send_request(FUNC_TEST, 2, 0);
        send_request(FUNC_TEST, 3, 0);
        send_request(FUNC_TEST, 4, 0);
        send_request(FUNC_TEST, 65521, 0);
        send_request(FUNC_TEST, 65537, 0);
        send_request(FUNC_TEST, 32'hFFFF_FFFF, 0);
        send_request(FUNC_TEST, 32'hFFFF_FFFB, 0);  // largest 32-bit prime, walks whole table
        send_request(FUNC_TEST, 32'd4293001441, 0); // square of the largest stored prime
        send_request(FUNC_TEST, 32'h8000_0000, 0);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 0);
        send_request(FUNC_LOOKUP, 0, 1);
        send_request(FUNC_LOOKUP, 0, 6541);
        send_request(FUNC_LOOKUP, 0, 6542);
        send_request(FUNC_LOOKUP, 0, 8191);
        send_request(FUNC_LOOKUP, 0, 16'hFFFF);

        // pause until everything is back
        drain();

        // random: tests of mostly small numbers with a share of full-width ones, and lookups
        for (int i = 0; i < 100; i++) begin
            if (i % 20 == 0) gap_max = (i % 40 == 0) ? 12 : 0;
            sel = $urandom_range(99, 0);
            if (sel < 35) begin
                n = $urandom_range(70000, 0);
                send_request(FUNC_TEST, n, 16'($urandom));
            end else if (sel < 55) begin
                n = $urandom;
                send_request(FUNC_TEST, n, 16'($urandom));
            end else if (sel < 90) begin
                send_request(FUNC_LOOKUP, $urandom, 16'($urandom_range(7000, 0)));
            end else begin
                send_request(FUNC_LOOKUP, $urandom, 16'($urandom));
            end
        end
        drain();

        $display("covered %0d primality tests and %0d lookups, %0d result beats checked",
                 sb.n_tests, sb.n_lookups, sb.n_checked);
        $display("%0d mismatches", sb.n_mismatch);
        if (sb.n_mismatch == 0 && sb.answers_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000000;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
rtl/pst_pkg.sv
rtl/prime_sieve_and_test.sv
rtl/pst_check.sv
tb/prime_sieve_and_test_test.sv
